FILE: rtl/tmg_pkg.sv
package tmg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_STEPS        = 24;

  // Q2.30 start value of the x register; it folds in the CORDIC gain.
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q16         = 32'sd65536;

  // Arctangent of 2**-i in turns/2**32.
  localparam logic signed [32:0] ATAN_TURNS [MAX_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  typedef enum logic [2:0] {
    CMD_EULER     = 3'd0,
    CMD_ROT_X     = 3'd1,
    CMD_ROT_Y     = 3'd2,
    CMD_ROT_Z     = 3'd3,
    CMD_SCALE     = 3'd4,
    CMD_TRANSLATE = 3'd5
  } cmd_e;

  // Right shift that rounds to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< ((s > 0) ? (s - 1) : 0);
    if (s == 0) begin
      return v;
    end else if (v >= 0) begin
      return (v + half) >>> s;
    end else begin
      return -(((-v) + half) >>> s);
    end
  endfunction

  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int frac);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'(rnd_shr(p, frac));
  endfunction

  function automatic logic [31:0] to_q16(input logic signed [63:0] v, input int frac);
    if (frac >= 16) begin
      return 32'(rnd_shr(v, frac - 16));
    end else begin
      return 32'(v <<< (16 - frac));
    end
  endfunction

endpackage

FILE: rtl/transform_matrix_generator.sv
// Transform matrix generator. Each accepted command beat (Euler rotation Rz*Ry*Rx,
// rotation about X, Y or Z, scale or translate) produces sixteen output beats, the
// entries of a 4x4 homogeneous matrix in row-major order in signed Q16.16, with
// last_entry_o set on entry (3,3). Sine and cosine of the three angles come from
// three unrolled CORDIC pipelines of CORDIC_STEPS stages, followed by a quadrant and
// rounding stage and two multiply stages. The output side emits one
// entry a cycle unless out_stall_i holds it; the matrix buffer at the end is loaded
// while the previous matrix sends its final beat, and commands keep entering the
// pipeline while a matrix waits to be taken, until a finished matrix in the second
// multiply stage finds the buffer still sending.
module transform_matrix_generator #(
  parameter int CORDIC_STEPS = tmg_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = tmg_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] arg_x_i,
  input  logic signed [31:0] arg_y_i,
  input  logic signed [31:0] arg_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_index_o,
  output logic [1:0]         col_index_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_entry_o
);

  localparam int S  = CORDIC_STEPS;
  localparam int F  = FRAC_BITS;
  localparam int CW = F + 3;

  logic signed [31:0] arg_in [3];
  assign arg_in[0] = arg_x_i;
  assign arg_in[1] = arg_y_i;
  assign arg_in[2] = arg_z_i;

  // CORDIC pipeline, index 0 is the input register.
  logic               v_q   [S+1];
  logic [2:0]         cmd_q [S+1];
  logic signed [31:0] arg_q [S+1][3];
  logic [1:0]         quad_q[S+1][3];
  logic signed [33:0] x_q   [S+1][3];
  logic signed [33:0] y_q   [S+1][3];
  logic signed [32:0] z_q   [S+1][3];

  // Quadrant stage: cos and sin of each axis.
  logic               vq_q;
  logic [2:0]         cmdq_q;
  logic signed [31:0] argq_q [3];
  logic signed [CW-1:0] c_q  [3];
  logic signed [CW-1:0] s_q  [3];

  // First multiply stage.
  logic               v1_q;
  logic [2:0]         cmd1_q;
  logic signed [31:0] arg1_q [3];
  logic signed [CW-1:0] c1_q [3];
  logic signed [CW-1:0] s1_q [3];
  logic signed [CW-1:0] czcy_q, sysx_q, sycx_q, szcx_q, szsx_q;
  logic signed [CW-1:0] szcy_q, czcx_q, czsx_q, cysx_q, cycx_q;

  // Second multiply stage.
  logic               v2_q;
  logic [2:0]         cmd2_q;
  logic signed [31:0] arg2_q [3];
  logic signed [CW-1:0] c2_q [3];
  logic signed [CW-1:0] s2_q [3];
  logic signed [CW-1:0] czcy2_q, szcx2_q, szsx2_q, szcy2_q, czcx2_q, czsx2_q;
  logic signed [CW-1:0] cysx2_q, cycx2_q;
  logic signed [CW-1:0] czsysx_q, czsycx_q, szsysx_q, szsycx_q;

  // Matrix buffer and serialiser.
  logic        mat_v_q, mat_v_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] mat_q [16];
  logic [31:0] mat_d [16];

  logic out_beat, mat_free, en;

  assign out_beat = mat_v_q && !out_stall_i;
  assign mat_free = !mat_v_q || (out_beat && (&cnt_q));
  // The whole pipeline moves as one; it only holds when a finished matrix
  // is waiting behind a buffer that is still sending.
  assign en         = !v2_q || mat_free;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= S; k++) begin
        v_q[k] <= 1'b0;
      end
      vq_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 0; k < S; k++) begin
        v_q[k+1] <= v_q[k];
      end
      vq_q <= v_q[S];
      v1_q <= vq_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[0] <= command_i;
      for (int a = 0; a < 3; a++) begin
        arg_q[0][a]  <= arg_in[a];
        quad_q[0][a] <= arg_in[a][15:14];
        x_q[0][a]    <= tmg_pkg::CORDIC_GAIN_Q30;
        y_q[0][a]    <= '0;
        z_q[0][a]    <= {3'b000, arg_in[a][13:0], 16'h0000};
      end
      for (int k = 0; k < S; k++) begin
        cmd_q[k+1] <= cmd_q[k];
        for (int a = 0; a < 3; a++) begin
          arg_q[k+1][a]  <= arg_q[k][a];
          quad_q[k+1][a] <= quad_q[k][a];
          if (z_q[k][a] >= 0) begin
            x_q[k+1][a] <= x_q[k][a] - (y_q[k][a] >>> k);
            y_q[k+1][a] <= y_q[k][a] + (x_q[k][a] >>> k);
            z_q[k+1][a] <= z_q[k][a] - tmg_pkg::ATAN_TURNS[k];
          end else begin
            x_q[k+1][a] <= x_q[k][a] + (y_q[k][a] >>> k);
            y_q[k+1][a] <= y_q[k][a] - (x_q[k][a] >>> k);
            z_q[k+1][a] <= z_q[k][a] + tmg_pkg::ATAN_TURNS[k];
          end
        end
      end
    end
  end

  // Quadrant map and rounding to FRAC_BITS.
  logic signed [33:0] cq [3];
  logic signed [33:0] sq [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (quad_q[S][a])
        2'd0: begin cq[a] = x_q[S][a];  sq[a] = y_q[S][a];  end
        2'd1: begin cq[a] = -y_q[S][a]; sq[a] = x_q[S][a];  end
        2'd2: begin cq[a] = -x_q[S][a]; sq[a] = -y_q[S][a]; end
        default: begin cq[a] = y_q[S][a]; sq[a] = -x_q[S][a]; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmdq_q <= cmd_q[S];
      for (int a = 0; a < 3; a++) begin
        argq_q[a] <= arg_q[S][a];
        c_q[a]    <= CW'(tmg_pkg::rnd_shr(64'(cq[a]), 30 - F));
        s_q[a]    <= CW'(tmg_pkg::rnd_shr(64'(sq[a]), 30 - F));
      end
    end
  end

  // Axis order: 0 is x, 1 is y, 2 is z.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= cmdq_q;
      for (int a = 0; a < 3; a++) begin
        arg1_q[a] <= argq_q[a];
        c1_q[a]   <= c_q[a];
        s1_q[a]   <= s_q[a];
      end
      czcy_q <= CW'(tmg_pkg::fmul(32'(c_q[2]), 32'(c_q[1]), F));
      sysx_q <= CW'(tmg_pkg::fmul(32'(s_q[1]), 32'(s_q[0]), F));
      sycx_q <= CW'(tmg_pkg::fmul(32'(s_q[1]), 32'(c_q[0]), F));
      szcx_q <= CW'(tmg_pkg::fmul(32'(s_q[2]), 32'(c_q[0]), F));
      szsx_q <= CW'(tmg_pkg::fmul(32'(s_q[2]), 32'(s_q[0]), F));
      szcy_q <= CW'(tmg_pkg::fmul(32'(s_q[2]), 32'(c_q[1]), F));
      czcx_q <= CW'(tmg_pkg::fmul(32'(c_q[2]), 32'(c_q[0]), F));
      czsx_q <= CW'(tmg_pkg::fmul(32'(c_q[2]), 32'(s_q[0]), F));
      cysx_q <= CW'(tmg_pkg::fmul(32'(c_q[1]), 32'(s_q[0]), F));
      cycx_q <= CW'(tmg_pkg::fmul(32'(c_q[1]), 32'(c_q[0]), F));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd2_q <= cmd1_q;
      for (int a = 0; a < 3; a++) begin
        arg2_q[a] <= arg1_q[a];
        c2_q[a]   <= c1_q[a];
        s2_q[a]   <= s1_q[a];
      end
      czcy2_q  <= czcy_q;
      szcx2_q  <= szcx_q;
      szsx2_q  <= szsx_q;
      szcy2_q  <= szcy_q;
      czcx2_q  <= czcx_q;
      czsx2_q  <= czsx_q;
      cysx2_q  <= cysx_q;
      cycx2_q  <= cycx_q;
      czsysx_q <= CW'(tmg_pkg::fmul(32'(c1_q[2]), 32'(sysx_q), F));
      czsycx_q <= CW'(tmg_pkg::fmul(32'(c1_q[2]), 32'(sycx_q), F));
      szsysx_q <= CW'(tmg_pkg::fmul(32'(s1_q[2]), 32'(sysx_q), F));
      szsycx_q <= CW'(tmg_pkg::fmul(32'(s1_q[2]), 32'(sycx_q), F));
    end
  end

  // Matrix assembly; every entry not set below stays zero.
  always_comb begin
    for (int e = 0; e < 16; e++) begin
      mat_d[e] = '0;
    end
    unique case (tmg_pkg::cmd_e'(cmd2_q))
      tmg_pkg::CMD_EULER: begin
        mat_d[0]  = tmg_pkg::to_q16(64'(czcy2_q), F);
        mat_d[1]  = tmg_pkg::to_q16(64'(czsysx_q) - 64'(szcx2_q), F);
        mat_d[2]  = tmg_pkg::to_q16(64'(czsycx_q) + 64'(szsx2_q), F);
        mat_d[4]  = tmg_pkg::to_q16(64'(szcy2_q), F);
        mat_d[5]  = tmg_pkg::to_q16(64'(szsysx_q) + 64'(czcx2_q), F);
        mat_d[6]  = tmg_pkg::to_q16(64'(szsycx_q) - 64'(czsx2_q), F);
        mat_d[8]  = tmg_pkg::to_q16(-64'(s2_q[1]), F);
        mat_d[9]  = tmg_pkg::to_q16(64'(cysx2_q), F);
        mat_d[10] = tmg_pkg::to_q16(64'(cycx2_q), F);
      end
      tmg_pkg::CMD_ROT_X: begin
        mat_d[0]  = tmg_pkg::ONE_Q16;
        mat_d[5]  = tmg_pkg::to_q16(64'(c2_q[0]), F);
        mat_d[6]  = tmg_pkg::to_q16(-64'(s2_q[0]), F);
        mat_d[9]  = tmg_pkg::to_q16(64'(s2_q[0]), F);
        mat_d[10] = tmg_pkg::to_q16(64'(c2_q[0]), F);
      end
      tmg_pkg::CMD_ROT_Y: begin
        mat_d[0]  = tmg_pkg::to_q16(64'(c2_q[1]), F);
        mat_d[2]  = tmg_pkg::to_q16(64'(s2_q[1]), F);
        mat_d[5]  = tmg_pkg::ONE_Q16;
        mat_d[8]  = tmg_pkg::to_q16(-64'(s2_q[1]), F);
        mat_d[10] = tmg_pkg::to_q16(64'(c2_q[1]), F);
      end
      tmg_pkg::CMD_ROT_Z: begin
        mat_d[0]  = tmg_pkg::to_q16(64'(c2_q[2]), F);
        mat_d[1]  = tmg_pkg::to_q16(-64'(s2_q[2]), F);
        mat_d[4]  = tmg_pkg::to_q16(64'(s2_q[2]), F);
        mat_d[5]  = tmg_pkg::to_q16(64'(c2_q[2]), F);
        mat_d[10] = tmg_pkg::ONE_Q16;
      end
      tmg_pkg::CMD_SCALE: begin
        mat_d[0]  = arg2_q[0];
        mat_d[5]  = arg2_q[1];
        mat_d[10] = arg2_q[2];
      end
      tmg_pkg::CMD_TRANSLATE: begin
        mat_d[0]  = tmg_pkg::ONE_Q16;
        mat_d[5]  = tmg_pkg::ONE_Q16;
        mat_d[10] = tmg_pkg::ONE_Q16;
        mat_d[3]  = arg2_q[0];
        mat_d[7]  = arg2_q[1];
        mat_d[11] = arg2_q[2];
      end
      default: begin
        mat_d[0]  = tmg_pkg::ONE_Q16;
        mat_d[5]  = tmg_pkg::ONE_Q16;
        mat_d[10] = tmg_pkg::ONE_Q16;
      end
    endcase
    mat_d[15] = tmg_pkg::ONE_Q16;
  end

  always_comb begin
    mat_v_d = mat_v_q;
    cnt_d   = cnt_q;
    if (out_beat) begin
      cnt_d = cnt_q + 4'd1;
    end
    if (mat_free) begin
      mat_v_d = v2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      mat_v_q <= mat_v_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_free && v2_q) begin
      mat_q <= mat_d;
    end
  end

  assign out_valid_o   = mat_v_q;
  assign row_index_o   = cnt_q[3:2];
  assign col_index_o   = cnt_q[1:0];
  assign entry_value_o = mat_q[cnt_q];
  assign last_entry_o  = &cnt_q;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STEPS = 16;
  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 160;
  localparam int DRAIN_CYCLES = STEPS + 12;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;
  } entry_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        typed;   // expected matrix given by diag and m01 of this row
    logic signed [31:0] diag;
    logic signed [31:0] m01;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = tmg_pkg::CMD_EULER;
  logic signed [31:0] arg_x_i = '0;
  logic signed [31:0] arg_y_i = '0;
  logic signed [31:0] arg_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] row_index_o;
  logic [1:0] col_index_o;
  logic signed [31:0] entry_value_o;
  logic last_entry_o;

  entry_t pending_entries[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit timed_out = 1'b0;

  always #2 clk_i = ~clk_i;

  transform_matrix_generator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .arg_x_i, .arg_y_i, .arg_z_i,
    .out_valid_o, .out_stall_i, .row_index_o, .col_index_o, .entry_value_o, .last_entry_o
  );

  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
    logic signed [63:0] half;
    if (s == 0) return v;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    return round_shift(a * b, FRAC);
  endfunction

  function automatic void cordic_sincos(logic [31:0] arg, output logic signed [63:0] c,
                                        output logic signed [63:0] s);
    logic [31:0] phase;
    logic signed [63:0] x, y, z, nx, ci, si;
    phase = {arg[15:0], 16'h0};
    x = 64'(tmg_pkg::CORDIC_GAIN_Q30);
    y = 0;
    z = {34'd0, phase[29:0]};
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - 64'(tmg_pkg::ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + 64'(tmg_pkg::ATAN_TURNS[i]);
      end
      x = nx;
    end
    case (phase[31:30])
      2'd0: begin ci = x; si = y; end
      2'd1: begin ci = -y; si = x; end
      2'd2: begin ci = -x; si = -y; end
      default: begin ci = y; si = -x; end
    endcase
    c = round_shift(ci, 30 - FRAC);
    s = round_shift(si, 30 - FRAC);
  endfunction

  // Pushes the sixteen entries of the matrix that one command beat produces.
  task automatic predict_matrix(logic [2:0] cmd, logic [31:0] ax, logic [31:0] ay,
                                logic [31:0] az);
    logic signed [63:0] m[4][4];
    logic signed [63:0] cx, sx, cy, sy, cz, sz, one, v;
    bit native;
    entry_t e;
    one = 64'sd1 <<< FRAC;
    native = 1'b0;
    for (int r = 0; r < 4; r++) for (int c = 0; c < 4; c++) m[r][c] = 0;
    cordic_sincos(ax, cx, sx);
    cordic_sincos(ay, cy, sy);
    cordic_sincos(az, cz, sz);
    case (cmd)
      tmg_pkg::CMD_EULER: begin
        m[0][0] = qmul(cz, cy);
        m[0][1] = qmul(cz, qmul(sy, sx)) - qmul(sz, cx);
        m[0][2] = qmul(cz, qmul(sy, cx)) + qmul(sz, sx);
        m[1][0] = qmul(sz, cy);
        m[1][1] = qmul(sz, qmul(sy, sx)) + qmul(cz, cx);
        m[1][2] = qmul(sz, qmul(sy, cx)) - qmul(cz, sx);
        m[2][0] = -sy;
        m[2][1] = qmul(cy, sx);
        m[2][2] = qmul(cy, cx);
      end
      tmg_pkg::CMD_ROT_X: begin
        m[0][0] = one; m[1][1] = cx; m[1][2] = -sx; m[2][1] = sx; m[2][2] = cx;
      end
      tmg_pkg::CMD_ROT_Y: begin
        m[0][0] = cy; m[0][2] = sy; m[1][1] = one; m[2][0] = -sy; m[2][2] = cy;
      end
      tmg_pkg::CMD_ROT_Z: begin
        m[0][0] = cz; m[0][1] = -sz; m[1][0] = sz; m[1][1] = cz; m[2][2] = one;
      end
      tmg_pkg::CMD_SCALE: begin
        native = 1'b1;
        m[0][0] = {32'd0, ax}; m[1][1] = {32'd0, ay}; m[2][2] = {32'd0, az};
      end
      tmg_pkg::CMD_TRANSLATE: begin
        native = 1'b1;
        m[0][0] = 65536; m[1][1] = 65536; m[2][2] = 65536;
        m[0][3] = {32'd0, ax}; m[1][3] = {32'd0, ay}; m[2][3] = {32'd0, az};
      end
      default: begin
        m[0][0] = one; m[1][1] = one; m[2][2] = one;
      end
    endcase
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r == 3 && c == 3) v = 65536;
        else if (native) v = m[r][c];
        else v = round_shift(m[r][c], FRAC - 16);
        e.row = r[1:0];
        e.col = c[1:0];
        e.value = v[31:0];
        e.last = (r == 3 && c == 3);
        pending_entries.push_back(e);
      end
    end
  endtask

  // Drives one command beat and holds it until the block takes it. Valid stays
  // high after the beat so that a following beat can go out in the next cycle.
  task automatic send_command(logic [2:0] cmd, logic [31:0] ax, logic [31:0] ay,
                              logic [31:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    arg_x_i <= ax;
    arg_y_i <= ay;
    arg_z_i <= az;
    predict_matrix(cmd, ax, ay, az);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    while (pending_entries.size() != 0 && !timed_out) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return {16'($urandom), 16'h0};
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    entry_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{row_index_o, col_index_o, entry_value_o, last_entry_o};
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected entry r%0d c%0d %0d", got.row, got.col,
                                       got.value);
      end else begin
        want = pending_entries.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("entry mismatch: want r%0d c%0d %0d last %0b, got r%0d c%0d %0d last %0b",
                     want.row, want.col, want.value, want.last,
                     got.row, got.col, got.value, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  initial begin
    stim_row_t stim[$];
    stim = '{
      '{tmg_pkg::CMD_EULER,     32'h0,         32'h0,         32'h0,         1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_X,     32'h0,         32'h0,         32'h0,         1'b0, 0, 0},
      '{tmg_pkg::CMD_SCALE,     32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 65536, 0},
      '{tmg_pkg::CMD_TRANSLATE, 32'h0,         32'h0,         32'h0,         1'b1, 65536, 0},
      '{3'd6,                   32'h1234_5678, 32'h0,         32'hffff_ffff, 1'b1, 65536, 0},
      '{3'd7,                   32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 65536, 0},
      '{tmg_pkg::CMD_EULER,     32'h0000_4000, 32'h0000_8000, 32'h0000_c000, 1'b0, 0, 0},
      '{tmg_pkg::CMD_EULER,     32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_X,     32'h0000_4000, 32'h0,         32'h0,         1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_X,     32'hffff_2000, 32'h0,         32'h0,         1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_Y,     32'h0,         32'h0000_8000, 32'h0,         1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_Y,     32'h0,         32'h1234_ffff, 32'h0,         1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_Z,     32'h0,         32'h0,         32'h0000_c000, 1'b0, 0, 0},
      '{tmg_pkg::CMD_ROT_Z,     32'h0,         32'h0,         32'h0000_0001, 1'b0, 0, 0},
      '{tmg_pkg::CMD_SCALE,     32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 0, 0},
      '{tmg_pkg::CMD_TRANSLATE, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b0, 0, 0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 37;
    recv_idle_pct = 62;
    foreach (stim[i]) begin
      send_command(stim[i].cmd, stim[i].ax, stim[i].ay, stim[i].az);
      if (stim[i].typed) begin
        // Identity-shaped rows: patch the prediction with the values read off by hand.
        for (int k = 0; k < 16; k++) begin
          int idx;
          idx = pending_entries.size() - 16 + k;
          pending_entries[idx].value = (k % 5 == 0) ? stim[i].diag : stim[i].m01;
        end
      end
    end
    // Let the block empty completely before the random beats start.
    in_valid_i <= 1'b0;
    wait_drained();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 37;
      end else if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_command(3'($urandom_range(7)), rand_arg(), rand_arg(), rand_arg());
      if (timed_out) break;
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (timed_out) begin
      $display("tb_top: errors");
      $finish;
    end else if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("tb_top: clean");
      $finish;
    end else begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    wait (timed_out);
    $display("tb_top: errors");
    $finish;
  end

endmodule
